>>> design/bsd_pkg.sv
package bsd_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int LIMIT_WIDTH  = 16;
   localparam int WRITTEN_WIDTH = 16;
   localparam int BYTE_WIDTH   = 8;
   localparam int SEXTET_WIDTH = 6;
   localparam int CMP_WIDTH    = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

   // op queue between decode front and result back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_BYTE_LIMIT = 1'b0;

   // alphabet
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [SEXTET_WIDTH-1:0] LOWER_BASE  = 6'd26;
   localparam logic [SEXTET_WIDTH-1:0] DIGIT_BASE  = 6'd52;
   localparam logic [SEXTET_WIDTH-1:0] VALUE_PLUS  = 6'd62;
   localparam logic [SEXTET_WIDTH-1:0] VALUE_SLASH = 6'd63;

   typedef enum logic [1:0] {
      POS_FIRST,
      POS_SECOND,
      POS_THIRD,
      POS_FOURTH
   } group_pos_type;

   typedef struct packed {
      logic                    ok;
      logic [SEXTET_WIDTH-1:0] value;
   } sextet_type;

   // one queued operation: up to three candidate bytes, or an error result
   typedef struct packed {
      logic [2:0][BYTE_WIDTH-1:0] bytes;
      logic [1:0]                 n;
      logic                       eos;
      logic                       bad;
   } op_type;

   function automatic sextet_type char_value(input logic [7:0] c);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = SEXTET_WIDTH'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = SEXTET_WIDTH'(c - CHAR_LOWER_A) + LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = SEXTET_WIDTH'(c - CHAR_DIGIT_0) + DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         s.value = VALUE_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = VALUE_SLASH;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

>>> design/bsd_if.sv
interface bsd_req_if import bsd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] char_code;
   logic                  end_of_string;

   modport source (output valid, char_code, end_of_string, input ready);
   modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

interface bsd_rsp_if import bsd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [BYTE_WIDTH-1:0]    out_byte;
   logic                     byte_valid;
   logic                     last_of_run;
   logic                     bad_char;
   logic [WRITTEN_WIDTH-1:0] bytes_written;

   modport source (output valid, out_byte, byte_valid, last_of_run, bad_char, bytes_written,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last_of_run, bad_char, bytes_written,
                   output ready);
endinterface

>>> design/bsd_front.sv
module bsd_front import bsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bsd_req_if.sink    req_chan,
   input  logic       q_full,
   output logic       push,
   output op_type     push_op
);

   group_pos_type         group_ff, group_in;
   logic [SEXTET_WIDTH-1:0] held_ff, held_in;
   logic                  discard_ff, discard_in;
   logic                  accept;
   logic                  eos;
   sextet_type            sx;
   logic [SEXTET_WIDTH-1:0] u;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign eos    = req_chan.end_of_string;
   assign sx     = char_value(req_chan.char_code);
   assign u      = sx.value;

   always_comb begin
      group_in   = group_ff;
      held_in    = held_ff;
      discard_in = discard_ff;
      push       = 1'b0;
      push_op    = '0;
      push_op.eos = eos;
      if (accept) begin
         if (discard_ff) begin
            // swallow the rest of a bad string, report once at its end
            if (eos) begin
               push        = 1'b1;
               push_op.bad = 1'b1;
               group_in    = POS_FIRST;
               held_in     = '0;
               discard_in  = 1'b0;
            end
         end else if (!sx.ok) begin
            push        = 1'b1;
            push_op.bad = 1'b1;
            group_in    = POS_FIRST;
            held_in     = '0;
            discard_in  = !eos;
         end else begin
            unique case (group_ff)
               POS_FIRST: begin
                  held_in  = u;
                  group_in = POS_SECOND;
                  if (eos) begin
                     push             = 1'b1;
                     push_op.bytes[0] = {u, 2'b00};
                     push_op.n        = 2'd3;
                  end
               end
               POS_SECOND: begin
                  held_in          = {2'b00, u[3:0]};
                  group_in         = POS_THIRD;
                  push             = 1'b1;
                  push_op.bytes[0] = {held_ff, u[5:4]};
                  push_op.n        = 2'd1;
                  if (eos) begin
                     push_op.bytes[1] = {u[3:0], 4'h0};
                     push_op.n        = 2'd3;
                  end
               end
               POS_THIRD: begin
                  held_in          = {4'h0, u[1:0]};
                  group_in         = POS_FOURTH;
                  push             = 1'b1;
                  push_op.bytes[0] = {held_ff[3:0], u[5:2]};
                  push_op.n        = 2'd1;
                  if (eos) begin
                     push_op.bytes[1] = {u[1:0], 6'h00};
                     push_op.n        = 2'd2;
                  end
               end
               POS_FOURTH: begin
                  held_in          = '0;
                  group_in         = POS_FIRST;
                  push             = 1'b1;
                  push_op.bytes[0] = {held_ff[1:0], u};
                  push_op.n        = 2'd1;
               end
               default: begin
                  group_in = POS_FIRST;
               end
            endcase
            if (eos) begin
               group_in = POS_FIRST;
               held_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff   <= POS_FIRST;
         held_ff    <= '0;
         discard_ff <= 1'b0;
      end else begin
         group_ff   <= group_in;
         held_ff    <= held_in;
         discard_ff <= discard_in;
      end
   end

endmodule

>>> design/bsd_queue.sv
module bsd_queue import bsd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   op_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("op queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("op queue popped while empty");
`endif

endmodule

>>> design/bsd_back.sv
module bsd_back import bsd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LIMIT_WIDTH-1:0] byte_limit,
   input  logic                   head_valid,
   input  op_type                 head_op,
   output logic                   pop,
   bsd_rsp_if.source              rsp_chan
);

   logic [1:0]               idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]    out_byte_ff, out_byte_in;
   logic                     byte_valid_ff, byte_valid_in;
   logic                     last_ff, last_in;
   logic                     bad_ff, bad_in;
   logic [WRITTEN_WIDTH-1:0] written_ff, written_in;

   logic                   load;
   logic                   room;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   cap_next;
   logic                   last_byte;

   assign load      = !rsp_valid_ff || rsp_chan.ready;
   // count may still grow if below both the register limit and the counter ceiling
   assign room      = (CMP_WIDTH'(count_ff) < CMP_WIDTH'(byte_limit)) && (count_ff != COUNT_MAX);
   assign count_inc = count_ff + 1'b1;
   assign cap_next  = (CMP_WIDTH'(count_inc) == CMP_WIDTH'(byte_limit)) ||
                      (count_inc == COUNT_MAX);
   assign last_byte = (idx_ff == head_op.n - 2'd1);

   always_comb begin
      pop           = 1'b0;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      bad_in        = bad_ff;
      written_in    = written_ff;
      if (load && head_valid) begin
         priority if (head_op.bad) begin
            pop           = 1'b1;
            rsp_valid_in  = 1'b1;
            out_byte_in   = '0;
            byte_valid_in = 1'b0;
            last_in       = head_op.eos;
            bad_in        = 1'b1;
            written_in    = WRITTEN_WIDTH'(count_ff);
            if (head_op.eos) begin
               count_in = '0;
            end
         end else if (idx_ff < head_op.n && room) begin
            rsp_valid_in  = 1'b1;
            out_byte_in   = head_op.bytes[idx_ff];
            byte_valid_in = 1'b1;
            last_in       = head_op.eos && (last_byte || cap_next);
            bad_in        = 1'b0;
            written_in    = WRITTEN_WIDTH'(count_inc);
            count_in      = count_inc;
            if (last_byte || (head_op.eos && cap_next)) begin
               pop    = 1'b1;
               idx_in = '0;
               if (head_op.eos) begin
                  count_in = '0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            // remaining bytes dropped; an end still needs its closing result
            pop    = 1'b1;
            idx_in = '0;
            if (head_op.eos) begin
               rsp_valid_in  = 1'b1;
               out_byte_in   = '0;
               byte_valid_in = 1'b0;
               last_in       = 1'b1;
               bad_in        = 1'b0;
               written_in    = WRITTEN_WIDTH'(count_ff);
               count_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      bad_ff        <= bad_in;
      written_ff    <= written_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = out_byte_ff;
   assign rsp_chan.byte_valid    = byte_valid_ff;
   assign rsp_chan.last_of_run   = last_ff;
   assign rsp_chan.bad_char      = bad_ff;
   assign rsp_chan.bytes_written = written_ff;

`ifndef SYNTHESIS
   a_count_cleared_at_end: assert property (@(posedge clock) disable iff (reset)
      (pop && head_op.eos) |=> (count_ff == '0))
      else $error("byte count not cleared after end of string");

   a_no_empty_midstring_op: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head_op.bad && head_op.n == 2'd0) |-> head_op.eos)
      else $error("front queued an op with no bytes that does not end the string");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> (head_valid && !head_op.bad && idx_ff < head_op.n))
      else $error("byte index past the bytes of the current op");
`endif

endmodule

>>> design/base64_stream_decoder.sv
// Base64 stream decoder: takes one character per cycle on req_chan while the op queue has room
// and returns decoded bytes on rsp_chan, one result per cycle while rsp_chan is ready; a taken
// character passes the op queue, then the result register. A character that completes a byte
// yields one result; the end character of a string yields up to three (the zero-filled tail of
// an open group), and the single result-producing stage drains them while a four-entry op queue
// keeps accepting characters. Sustained input rate is one character per cycle as long as
// results are taken; the queue depth sets how long input keeps flowing while rsp_chan is
// stalled. Bytes beyond byte_limit (register 0, reset 65535) are dropped; an invalid character
// returns an error result and the rest of its string is skipped up to the end character.
module base64_stream_decoder import bsd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   bsd_req_if.sink                   req_chan,
   bsd_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [LIMIT_WIDTH-1:0]   limit_ff, limit_in;
   logic [CSR_IDX_WIDTH-1:0] csr_idx;
   logic                     csr_write;

   logic   push;
   op_type push_op;
   logic   q_full;
   logic   pop;
   logic   head_valid;
   op_type head_op;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && csr_idx == CSR_IDX_BYTE_LIMIT) begin
         limit_in = pwdata[LIMIT_WIDTH-1:0];
      end
      prdata = '0;
      if (csr_idx == CSR_IDX_BYTE_LIMIT) begin
         prdata = CSR_DATA_WIDTH'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   bsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_op  (push_op)
   );

   bsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   bsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .byte_limit (limit_ff),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
